// File: hdl/enms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// enms_pkg
// Shared constants and types of the edge non-maximum suppression block.
// ----------------------------------------------------------------------------
package enms_pkg;

  // Default sizes handed to the top level.
  localparam int ENMS_MAX_WIDTH = 2048;
  localparam int ENMS_MAG_BITS  = 16;

  // Row limit of a frame and register reset values.
  localparam logic [11:0] HEIGHT_CAP      = 12'd2048;
  localparam logic [11:0] WIDTH_RESET     = 12'd640;
  localparam logic [11:0] HEIGHT_RESET    = 12'd480;
  localparam logic [15:0] GRAD_MAX_RESET  = 16'hFFFF;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_WIDTH    = 2'd0;
  localparam logic [1:0] REG_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_GRAD_MAX = 2'd2;

  // Input operation codes.
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Rounded direction codes: offset minus one, plus one.
  localparam logic [1:0] DIR_NEG  = 2'd0;
  localparam logic [1:0] DIR_ZERO = 2'd1;
  localparam logic [1:0] DIR_POS  = 2'd2;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_CENTRE,
    S_GET_CENTRE,
    S_RD_MINUS,
    S_RD_PLUS,
    S_COMPARE,
    S_DIV_THIN,
    S_DIV_LEVEL,
    S_DONE
  } enms_state_t;

  // Round a Q1.14 component to the nearest offset, saturated to -1..1.
  function automatic logic [1:0] round_dir(input logic signed [15:0] v);
    logic [1:0] code;
    if (v < -16'sd8192) begin
      code = DIR_NEG;
    end else if (v >= 16'sd8192) begin
      code = DIR_POS;
    end else begin
      code = DIR_ZERO;
    end
    return code;
  endfunction

endpackage

// File: hdl/edge_non_maximum_suppression_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_non_maximum_suppression_top
// Canny edge thinning: raster pixels in, suppressed and normalised magnitudes out.
// ----------------------------------------------------------------------------
// Pixels arrive on the input channel (valid/ready) in raster order; op marks a
// pixel beat or a flush beat. The result for pixel k comes out once pixel
// k+W+1 has arrived; after the last pixel of a frame, one flush beat per
// outstanding pixel drains the final row and a pixel.
// A beat that yields a result holds off the next input beat while the sequencer
// works: reads from the line store (centre, then the two neighbours along the
// direction), a compare, then a shared one-bit-per-cycle divider that runs 16
// steps for the normalised value and 8 for the histogram level, and a load of
// the output register. A zero-offset pixel skips the neighbour reads and the
// divider; a suppressed or saturated one skips the divider.
// Results sit in an output register; the next input beat is taken while a
// result waits, and the sequencer only stalls before overwriting it.
// Reset is synchronous: registers return to 640 x 480 and gradient max 65535,
// and the frame counters clear. The line store needs no clearing pass. Width or height
// are to be written over the APB port only while the block is idle; not enforced.
// ----------------------------------------------------------------------------
module edge_non_maximum_suppression_top
  import enms_pkg::*;
#(
  parameter int MAX_WIDTH = ENMS_MAX_WIDTH,
  parameter int MAG_BITS  = ENMS_MAG_BITS
) (
  input  logic               clk,
  input  logic               rst,
  // APB configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // Input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               op,
  input  logic [15:0]        magnitude,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_y,
  // Output channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        thinned,
  output logic [7:0]         level,
  output logic               counted,
  output logic               frame_end
);

  localparam int DEPTH = 2 * MAX_WIDTH + 4;
  localparam int AW    = $clog2(DEPTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int LW    = $clog2(MAX_WIDTH + 3);
  localparam int CW    = (MAG_BITS > 16) ? MAG_BITS : 16;
  localparam int RW    = MAG_BITS + 4;
  localparam int SW    = AW + 2;

  // Configuration registers.
  logic [11:0] image_width;
  logic [11:0] image_height;
  logic [15:0] gradient_max;

  // Frame position counters and store pointers.
  logic [WW-1:0] in_col;
  logic [11:0]   in_row;
  logic [WW-1:0] out_col;
  logic [11:0]   out_row;
  logic [LW-1:0] lead;
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] out_ptr;

  // Centre of the result under work.
  logic [WW-1:0]       c_col;
  logic [11:0]         c_row;
  logic [AW-1:0]       c_ptr;
  logic [MAG_BITS-1:0] g0;
  logic [MAG_BITS-1:0] gm;
  logic [1:0]          dxc;
  logic [1:0]          dyc;
  logic [24:0]         n_lvl;

  // Divider.
  logic [17:0] rem;
  logic [15:0] num;
  logic [16:0] dvs;
  logic [15:0] quo;
  logic [4:0]  div_cnt;

  // Finished result.
  logic [15:0] res_thin;
  logic [7:0]  res_lvl;
  logic        res_cnt;

  enms_state_t state;
  enms_state_t state_next;

  // RAM connections.
  logic          ram_we;
  logic [RW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [RW-1:0] ram_rdata;

  // Effective frame sizes and divisor.
  logic [WW-1:0] w_eff;
  logic [11:0]   h_eff;
  logic [15:0]   gdiv;

  always_comb begin
    if (image_width == 12'd0) begin
      w_eff = WW'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(image_width);
    end
    if (image_height == 12'd0) begin
      h_eff = 12'd1;
    end else if (image_height > HEIGHT_CAP) begin
      h_eff = HEIGHT_CAP;
    end else begin
      h_eff = image_height;
    end
    gdiv = (gradient_max == 16'd0) ? 16'd1 : gradient_max;
  end

  // APB access.
  logic       cfg_wr;
  logic [1:0] cfg_idx;
  logic       size_wr;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign size_wr = cfg_wr && (cfg_idx == REG_WIDTH || cfg_idx == REG_HEIGHT);

  always_comb begin
    unique case (cfg_idx)
      REG_WIDTH:    prdata = 32'(image_width);
      REG_HEIGHT:   prdata = 32'(image_height);
      REG_GRAD_MAX: prdata = 32'(gradient_max);
      default:      prdata = 32'd0;
    endcase
  end

  // Input beat decode.
  logic          in_fire;
  logic          in_full;
  logic          out_done;
  logic          restart;
  logic          pix_write;
  logic          emit_pix;
  logic          emit_flush;
  logic          emit;
  logic [WW-1:0] b_in_col;
  logic [11:0]   b_in_row;
  logic [WW-1:0] b_out_col;
  logic [11:0]   b_out_row;
  logic [LW-1:0] b_lead;
  logic [AW-1:0] b_out_ptr;
  logic [LW-1:0] lead_inc;

  assign in_ready   = (state == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign in_full    = (in_row == h_eff);
  assign out_done   = (out_row == h_eff);
  assign restart    = (op == OP_PIXEL) && in_full && out_done;
  assign pix_write  = in_fire && (op == OP_PIXEL) && (!in_full || out_done);
  assign emit_flush = in_fire && (op == OP_FLUSH) && in_full && !out_done;
  assign b_in_col   = restart ? '0 : in_col;
  assign b_in_row   = restart ? '0 : in_row;
  assign b_out_col  = restart ? '0 : out_col;
  assign b_out_row  = restart ? '0 : out_row;
  assign b_lead     = restart ? '0 : lead;
  assign b_out_ptr  = restart ? wr_ptr : out_ptr;
  assign lead_inc   = b_lead + LW'(1);
  assign emit_pix   = pix_write && ((LW + 1)'(lead_inc) >= (LW + 1)'(w_eff) + (LW + 1)'(2));
  assign emit       = emit_pix || emit_flush;

  assign ram_we    = pix_write;
  assign ram_wdata = {round_dir(dir_y), round_dir(dir_x), MAG_BITS'(magnitude)};

  // Neighbour addresses along the rounded direction.
  logic signed [SW-1:0] off_p;
  logic signed [SW-1:0] sum_p;
  logic signed [SW-1:0] sum_m;
  logic [AW-1:0]        addr_p;
  logic [AW-1:0]        addr_m;
  logic                 ok_p;
  logic                 ok_m;
  logic signed [SW-1:0] depth_s;
  logic signed [SW-1:0] w_s;
  logic signed [SW-1:0] ptr_s;

  assign depth_s = $signed(SW'(DEPTH));
  assign w_s     = $signed(SW'(w_eff));
  assign ptr_s   = $signed(SW'(c_ptr));

  always_comb begin
    off_p = '0;
    if (dyc == DIR_POS) begin
      off_p = w_s;
    end else if (dyc == DIR_NEG) begin
      off_p = -w_s;
    end
    if (dxc == DIR_POS) begin
      off_p = off_p + SW'(1);
    end else if (dxc == DIR_NEG) begin
      off_p = off_p - SW'(1);
    end
    sum_p = ptr_s + off_p;
    sum_m = ptr_s - off_p;
    if (sum_p < 0) begin
      sum_p = sum_p + depth_s;
    end else if (sum_p >= depth_s) begin
      sum_p = sum_p - depth_s;
    end
    if (sum_m < 0) begin
      sum_m = sum_m + depth_s;
    end else if (sum_m >= depth_s) begin
      sum_m = sum_m - depth_s;
    end
    addr_p = AW'(sum_p);
    addr_m = AW'(sum_m);
  end

  // Neighbours outside the frame read as zero.
  assign ok_p = !(dyc == DIR_NEG && c_row == 12'd0) &&
                !(dyc == DIR_POS && c_row == h_eff - 12'd1) &&
                !(dxc == DIR_NEG && c_col == '0) &&
                !(dxc == DIR_POS && c_col == w_eff - WW'(1));
  assign ok_m = !(dyc == DIR_POS && c_row == 12'd0) &&
                !(dyc == DIR_NEG && c_row == h_eff - 12'd1) &&
                !(dxc == DIR_POS && c_col == '0) &&
                !(dxc == DIR_NEG && c_col == w_eff - WW'(1));

  // Read address by sequencer step.
  always_comb begin
    unique case (state)
      S_RD_MINUS: ram_raddr = addr_m;
      S_RD_PLUS:  ram_raddr = addr_p;
      default:    ram_raddr = c_ptr;
    endcase
  end

  enms_ram #(
    .WIDTH(RW),
    .DEPTH(DEPTH)
  ) u_lines (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Suppression test on the read neighbours.
  logic [MAG_BITS-1:0] rd_mag;
  logic [MAG_BITS-1:0] gp;
  logic                keep;
  logic                sat;

  assign rd_mag = ram_rdata[MAG_BITS-1:0];
  assign gp     = ok_p ? rd_mag : '0;
  assign keep   = (g0 >= gm) && (g0 >= gp);
  assign sat    = CW'(g0) >= CW'(gdiv);

  // One restoring division step.
  logic [17:0] trial;
  logic        ge;
  logic [17:0] rem_step;
  logic [15:0] quo_step;

  assign trial    = {rem[16:0], num[15]};
  assign ge       = trial >= 18'(dvs);
  assign rem_step = ge ? trial - 18'(dvs) : trial;
  assign quo_step = {quo[14:0], ge};

  // Output register may be loaded.
  logic out_free;
  assign out_free = !out_valid || out_ready;

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:       if (emit) state_next = S_RD_CENTRE;
      S_RD_CENTRE:  state_next = S_GET_CENTRE;
      S_GET_CENTRE: begin
        if (ram_rdata[RW-1:RW-2] == DIR_ZERO && ram_rdata[RW-3:RW-4] == DIR_ZERO) begin
          state_next = S_DONE;
        end else begin
          state_next = S_RD_MINUS;
        end
      end
      S_RD_MINUS:   state_next = S_RD_PLUS;
      S_RD_PLUS:    state_next = S_COMPARE;
      S_COMPARE:    state_next = (keep && !sat) ? S_DIV_THIN : S_DONE;
      S_DIV_THIN:   if (div_cnt == 5'd0) state_next = S_DIV_LEVEL;
      S_DIV_LEVEL:  if (div_cnt == 5'd0) state_next = S_DONE;
      S_DONE:       if (out_free) state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers and frame counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      gradient_max <= GRAD_MAX_RESET;
      in_col       <= '0;
      in_row       <= '0;
      out_col      <= '0;
      out_row      <= '0;
      lead         <= '0;
      wr_ptr       <= '0;
      out_ptr      <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_WIDTH:    image_width  <= pwdata[11:0];
        REG_HEIGHT:   image_height <= pwdata[11:0];
        REG_GRAD_MAX: gradient_max <= pwdata[15:0];
        default:      ;
      endcase
      if (size_wr) begin
        in_col  <= '0;
        in_row  <= '0;
        out_col <= '0;
        out_row <= '0;
        lead    <= '0;
        out_ptr <= wr_ptr;
      end
    end else if (in_fire) begin
      if (pix_write) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
        if (b_in_col == w_eff - WW'(1)) begin
          in_col <= '0;
          in_row <= b_in_row + 12'd1;
        end else begin
          in_col <= b_in_col + WW'(1);
          in_row <= b_in_row;
        end
        lead <= emit_pix ? b_lead : lead_inc;
      end else if (emit_flush) begin
        lead <= lead - LW'(1);
      end
      if (pix_write || emit_flush) begin
        if (emit) begin
          out_ptr <= (b_out_ptr == AW'(DEPTH - 1)) ? '0 : b_out_ptr + AW'(1);
          if (b_out_col == w_eff - WW'(1)) begin
            out_col <= '0;
            out_row <= b_out_row + 12'd1;
          end else begin
            out_col <= b_out_col + WW'(1);
            out_row <= b_out_row;
          end
        end else begin
          out_ptr <= b_out_ptr;
          out_col <= b_out_col;
          out_row <= b_out_row;
        end
      end
    end
  end

  // Datapath of the sequencer.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (emit) begin
          c_col <= b_out_col;
          c_row <= b_out_row;
          c_ptr <= b_out_ptr;
        end
      end
      S_GET_CENTRE: begin
        g0       <= rd_mag;
        dxc      <= ram_rdata[RW-3:RW-4];
        dyc      <= ram_rdata[RW-1:RW-2];
        res_thin <= 16'd0;
        res_lvl  <= 8'd0;
        res_cnt  <= 1'b0;
      end
      S_RD_PLUS: begin
        gm <= ok_m ? rd_mag : '0;
      end
      S_COMPARE: begin
        res_cnt <= keep;
        if (keep && sat) begin
          res_thin <= 16'hFFFF;
          res_lvl  <= 8'hFF;
        end
        n_lvl   <= 25'd510 * 25'(16'(g0)) + 25'(gdiv);
        rem     <= 18'(16'(g0));
        num     <= 16'd0;
        dvs     <= {1'b0, gdiv};
        quo     <= 16'd0;
        div_cnt <= 5'd15;
      end
      S_DIV_THIN: begin
        if (div_cnt == 5'd0) begin
          res_thin <= quo_step;
          rem      <= 18'(n_lvl[24:8]);
          num      <= {n_lvl[7:0], 8'd0};
          dvs      <= {gdiv, 1'b0};
          quo      <= 16'd0;
          div_cnt  <= 5'd7;
        end else begin
          rem     <= rem_step;
          num     <= {num[14:0], 1'b0};
          quo     <= quo_step;
          div_cnt <= div_cnt - 5'd1;
        end
      end
      S_DIV_LEVEL: begin
        rem     <= rem_step;
        num     <= {num[14:0], 1'b0};
        quo     <= quo_step;
        div_cnt <= div_cnt - 5'd1;
        if (div_cnt == 5'd0) begin
          res_lvl <= quo_step[7:0];
        end
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      thinned   <= res_thin;
      level     <= res_lvl;
      counted   <= res_cnt;
      frame_end <= (c_row == h_eff - 12'd1) && (c_col == w_eff - WW'(1));
    end
  end

endmodule

// File: hdl/enms_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// enms_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module enms_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 4100
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read data registered; a read of the entry being written returns the old value.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: dv/enms_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// enms_checker
// Watches the configuration port and both channels of the edge non-maximum
// suppression block. It keeps its own copy of the line stores and frame
// counters, works out any result that an accepted beat yields and compares each
// output beat, field by field, with the oldest result still awaited.
// ----------------------------------------------------------------------------
module enms_checker
  import enms_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               op,
  input  logic [15:0]        magnitude,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_y,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [15:0]        thinned,
  input  logic [7:0]         level,
  input  logic               counted,
  input  logic               frame_end,
  output int                 fail_count,
  output int                 pending
);

  localparam int MAG_STORE = 2 * ENMS_MAX_WIDTH + 4;
  localparam int OFS_STORE = ENMS_MAX_WIDTH + 2;

  typedef struct packed {
    logic [15:0] thinned;
    logic [7:0]  level;
    logic        counted;
    logic        frame_end;
  } nms_result_t;

  // Shadow registers, line stores and frame position.
  logic [11:0] width_reg;
  logic [11:0] height_reg;
  logic [15:0] grad_max_reg;
  logic [15:0] mag_store [MAG_STORE];
  logic [3:0]  ofs_store [OFS_STORE];
  int unsigned col_pos;
  int unsigned row_pos;
  int unsigned next_out;
  nms_result_t awaited_q[$];

  // Nearest offset code of a Q1.14 component, saturated to -1..1.
  function automatic logic [1:0] dir_code(input logic signed [15:0] v);
    int t;
    t = (int'(v) + 8192 + 49152) >>> 14;
    t = t - 3;
    if (t < -1) t = -1;
    if (t > 1) t = 1;
    return 2'(t + 1);
  endfunction

  // Magnitude of a neighbour of pixel k; zero outside the image.
  function automatic int unsigned neighbour(input int unsigned k, input int unsigned w,
                                            input int unsigned rows, input int di,
                                            input int dj);
    int r;
    int c;
    r = int'(k / w) + di;
    c = int'(k % w) + dj;
    if (r < 0 || r >= int'(rows) || c < 0 || c >= int'(w)) return 0;
    return mag_store[(int'(k) + di * int'(w) + dj) % MAG_STORE];
  endfunction

  // Suppression decision and normalisation of pixel k.
  task automatic predict_pixel(input int unsigned k, input int unsigned w,
                               input int unsigned total);
    nms_result_t res;
    int dx;
    int dy;
    longint unsigned g0;
    longint unsigned gm;
    longint unsigned gp;
    longint unsigned div;
    longint unsigned q;
    longint unsigned l;
    dx = int'(ofs_store[k % OFS_STORE][1:0]) - 1;
    dy = int'(ofs_store[k % OFS_STORE][3:2]) - 1;
    res = '0;
    if (dx != 0 || dy != 0) begin
      g0 = neighbour(k, w, total / w, 0, 0);
      gm = neighbour(k, w, total / w, -dy, -dx);
      gp = neighbour(k, w, total / w, dy, dx);
      if (g0 >= gm && g0 >= gp) begin
        div = (grad_max_reg == 0) ? 1 : grad_max_reg;
        q = (g0 << 16) / div;
        l = (510 * g0 + div) / (2 * div);
        res.thinned = (q > 65535) ? 16'hFFFF : 16'(q);
        res.level   = (l > 255) ? 8'hFF : 8'(l);
        res.counted = 1'b1;
      end
    end
    res.frame_end = (k + 1 == total);
    awaited_q.push_back(res);
  endtask

  // Advance the frame by one accepted input beat.
  task automatic take_beat(input logic is_op, input logic [15:0] mag,
                           input logic signed [15:0] vx, input logic signed [15:0] vy);
    int unsigned w;
    int unsigned h;
    int unsigned total;
    int unsigned arrived;
    w = (width_reg == 0) ? 1 : (width_reg > ENMS_MAX_WIDTH) ? ENMS_MAX_WIDTH : width_reg;
    h = (height_reg == 0) ? 1 : (height_reg > HEIGHT_CAP) ? HEIGHT_CAP : height_reg;
    total = w * h;
    if (row_pos >= h) begin
      row_pos = h;
      col_pos = 0;
    end
    if (col_pos >= w) col_pos = 0;
    arrived = row_pos * w + col_pos;
    if (next_out > arrived) next_out = arrived;
    if (is_op == OP_PIXEL) begin
      if (arrived == total) begin
        // A completed frame ignores pixels until it has drained.
        if (next_out < total) return;
        row_pos = 0;
        col_pos = 0;
        next_out = 0;
        arrived = 0;
      end
      mag_store[arrived % MAG_STORE] = mag;
      ofs_store[arrived % OFS_STORE] = {dir_code(vy), dir_code(vx)};
      col_pos++;
      if (col_pos == w) begin
        col_pos = 0;
        row_pos++;
      end
      arrived++;
      if (arrived >= next_out + w + 2) begin
        predict_pixel(next_out, w, total);
        next_out++;
      end
    end else if (arrived == total && next_out < total) begin
      predict_pixel(next_out, w, total);
      next_out++;
    end
  endtask

  task automatic report(input string what, input int unsigned got, input int unsigned want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  // Compare, then predict, at every edge.
  always @(posedge clk) begin
    nms_result_t want;
    if (rst) begin
      width_reg    = WIDTH_RESET;
      height_reg   = HEIGHT_RESET;
      grad_max_reg = GRAD_MAX_RESET;
      foreach (mag_store[i]) mag_store[i] = '0;
      foreach (ofs_store[i]) ofs_store[i] = '0;
      col_pos  = 0;
      row_pos  = 0;
      next_out = 0;
      awaited_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_q.size() == 0) begin
          $display("[%0t] result beat with nothing awaited", $time);
          fail_count++;
        end else begin
          want = awaited_q.pop_front();
          if (thinned !== want.thinned) report("thinned", thinned, want.thinned);
          if (level !== want.level) report("level", level, want.level);
          if (counted !== want.counted) report("counted", counted, want.counted);
          if (frame_end !== want.frame_end) report("frame_end", frame_end, want.frame_end);
        end
      end
      if (psel && penable && pwrite && pready) begin
        // Writing a frame size abandons the frame in progress.
        case (paddr[3:2])
          REG_WIDTH: begin
            width_reg = pwdata[11:0];
            col_pos = 0;
            row_pos = 0;
            next_out = 0;
          end
          REG_HEIGHT: begin
            height_reg = pwdata[11:0];
            col_pos = 0;
            row_pos = 0;
            next_out = 0;
          end
          REG_GRAD_MAX: grad_max_reg = pwdata[15:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) take_beat(op, magnitude, dir_x, dir_y);
    end
    pending <= awaited_q.size();
  end

endmodule

// File: dv/tb_edge_non_maximum_suppression_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_edge_non_maximum_suppression_top
// Frame stimulus for the edge non-maximum suppression block.
// ----------------------------------------------------------------------------
// A directed frame covers every direction code, the rounding edges and the
// magnitude extremes, early and surplus flushes and an abandoned frame. A
// frame with zero sizes and random frames of small sizes follow, with a pixel
// sent before the frame has drained. Both channels stall at random; the checker
// beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_edge_non_maximum_suppression_top;
  import enms_pkg::*;

  localparam int IDLE_LIMIT  = 4000;
  localparam int QUIET_TICKS = 40;

  // Register index with no register behind it.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               op = OP_PIXEL;
  logic [15:0]        magnitude = '0;
  logic signed [15:0] dir_x = '0;
  logic signed [15:0] dir_y = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [15:0]        thinned;
  logic [7:0]         level;
  logic               counted;
  logic               frame_end;
  int                 fail_count;
  int                 pending;
  int                 beats_sent;
  int                 idle_ticks;
  int                 hold_ticks;
  bit                 calm;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  edge_non_maximum_suppression_top u_top (.*);

  enms_checker u_checker (.*);

  // Random gap length: mostly none or short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result side back-pressure, held for random stretches.
  always @(posedge clk) begin
    if (rst || calm) begin
      out_ready  <= 1'b1;
      hold_ticks <= 0;
    end else if (hold_ticks > 0) begin
      hold_ticks <= hold_ticks - 1;
    end else begin
      out_ready  <= ($urandom_range(0, 2) != 0);
      hold_ticks <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(0, 3);
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      idle_ticks <= 0;
    end else begin
      idle_ticks <= idle_ticks + 1;
      if (idle_ticks >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Register write once every awaited result has arrived.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (QUIET_TICKS) @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // One input beat; valid stays high into the next beat when no gap follows.
  task automatic send_beat(input logic is_op, input logic [15:0] mag,
                           input logic signed [15:0] vx, input logic signed [15:0] vy);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    op        <= is_op;
    magnitude <= mag;
    dir_x     <= vx;
    dir_y     <= vy;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  function automatic logic [15:0] pick_mag();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 3));
      3: return 16'($urandom_range(0, 300));
      default: return 16'($urandom);
    endcase
  endfunction

  // Directions near the rounding points, the range ends and elsewhere.
  function automatic logic signed [15:0] pick_dir();
    case ($urandom_range(0, 9))
      0: return 16'sd8192;
      1: return 16'sd8191;
      2: return -16'sd8192;
      3: return -16'sd8193;
      4: return 16'sd16384;
      5: return -16'sd16384;
      6: return 16'sd0;
      7: return 16'($urandom);
      default: return 16'(int'($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  // A whole frame with its drain; odd beats thrown in on request.
  task automatic run_frame(input logic [11:0] w_reg, input logic [11:0] h_reg,
                           input bit odd_beats);
    int w;
    int h;
    w = (w_reg == 0) ? 1 : (w_reg > ENMS_MAX_WIDTH) ? ENMS_MAX_WIDTH : w_reg;
    h = (h_reg == 0) ? 1 : (h_reg > HEIGHT_CAP) ? HEIGHT_CAP : h_reg;
    write_reg(REG_WIDTH, 32'(w_reg));
    write_reg(REG_HEIGHT, 32'(h_reg));
    for (int i = 0; i < w * h; i++) begin
      if (odd_beats && $urandom_range(0, 15) == 0) begin
        send_beat(OP_FLUSH, pick_mag(), 16'sd0, 16'sd0);
      end
      send_beat(OP_PIXEL, pick_mag(), pick_dir(), pick_dir());
    end
    if (odd_beats) send_beat(OP_PIXEL, pick_mag(), pick_dir(), pick_dir());
    for (int i = 0; i <= w; i++) send_beat(OP_FLUSH, 16'($urandom), 16'($urandom), 16'($urandom));
    if (odd_beats) send_beat(OP_FLUSH, 16'h0, 16'h0, 16'h0);
  endtask

  initial begin
    beats_sent = 0;
    calm = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed frame of 3 x 2: every direction code and the field extremes.
    write_reg(REG_GRAD_MAX, 32'd1);
    write_reg(REG_WIDTH, 32'd3);
    write_reg(REG_HEIGHT, 32'd2);
    send_beat(OP_FLUSH, 16'h0, 16'h0, 16'h0);
    send_beat(OP_PIXEL, 16'hFFFF, -16'sd16384, -16'sd16384);
    send_beat(OP_PIXEL, 16'h0000, 16'sd0, -16'sd8193);
    send_beat(OP_PIXEL, 16'h8000, 16'sd16384, -16'sd8192);
    send_beat(OP_PIXEL, 16'h0001, -16'sd8193, 16'sd8191);
    send_beat(OP_PIXEL, 16'h0001, 16'sd8192, 16'sd0);
    send_beat(OP_PIXEL, 16'h7FFF, 16'sd8191, 16'sd16384);
    send_beat(OP_PIXEL, 16'h1234, 16'sd8192, 16'sd8192);
    for (int i = 0; i < 4; i++) send_beat(OP_FLUSH, 16'h0, 16'h0, 16'h0);
    send_beat(OP_FLUSH, 16'hFFFF, 16'shFFFF, 16'shFFFF);
    // Next frame starts after the drain; abandon it part way.
    send_beat(OP_PIXEL, 16'h0005, -16'sd1, 16'sd8192);
    send_beat(OP_PIXEL, 16'h0005, 16'sh7FFF, 16'sh8000);
    write_reg(REG_WIDTH, 32'd2);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    write_reg(REG_GRAD_MAX, 32'd0);
    run_frame(12'd2, 12'd2, 1'b0);

    // Zero sizes read as one, with free-flowing channels.
    calm = 1'b1;
    write_reg(REG_GRAD_MAX, 32'hFFFF);
    run_frame(12'd0, 12'd0, 1'b1);
    write_reg(REG_GRAD_MAX, 32'd300);
    calm = 1'b0;

    // Random small frames, with stretches of no idling now and then.
    while (beats_sent < 1100) begin
      if ($urandom_range(0, 2) == 0) begin
        write_reg(REG_GRAD_MAX, ($urandom_range(0, 1) == 0) ? $urandom_range(0, 400)
                                                            : $urandom_range(0, 65535));
      end
      calm = ($urandom_range(0, 4) == 0);
      run_frame(12'(($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8)),
                12'($urandom_range(1, 6)), $urandom_range(0, 2) == 0);
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (QUIET_TICKS) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: edge_non_maximum_suppression_top.f
hdl/enms_pkg.sv
hdl/enms_ram.sv
hdl/edge_non_maximum_suppression_top.sv
dv/enms_checker.sv
dv/tb_edge_non_maximum_suppression_top.sv
